### hw/rtl/rcpd_pkg.sv
// Package with shared types and constants of the RC pulse to bidirectional drive core.
package rcpd_pkg;

  localparam int CAL_W      = 16;
  localparam int FAIL_W     = 22;
  localparam int DB_W       = 8;
  localparam int DUTY_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [CAL_W-1:0]  MIN_WIDTH_RESET  = 16'd1100;
  localparam logic [CAL_W-1:0]  MAX_WIDTH_RESET  = 16'd1900;
  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RESET = 22'd2000000;
  localparam logic [DB_W-1:0]   DEAD_BAND_RESET  = 8'd50;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_WIDTH_ONE = 3'd0,
    REG_MAX_WIDTH_ONE = 3'd1,
    REG_MIN_WIDTH_TWO = 3'd2,
    REG_MAX_WIDTH_TWO = 3'd3,
    REG_FAIL_LIMIT    = 3'd4,
    REG_DEAD_BAND     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0]  min_width_one;
    logic [CAL_W-1:0]  max_width_one;
    logic [CAL_W-1:0]  min_width_two;
    logic [CAL_W-1:0]  max_width_two;
    logic [FAIL_W-1:0] fail_limit;
    logic [DB_W-1:0]   dead_band;
  } cfg_t;

  typedef struct packed {
    logic pulse_in_one;
    logic pulse_in_two;
  } in_item_t;

  typedef struct packed {
    logic              forward_one;
    logic [DUTY_W-1:0] duty_one;
    logic              forward_two;
    logic [DUTY_W-1:0] duty_two;
    logic              fail_safe;
  } out_item_t;

  typedef struct packed {
    logic track;
    logic ch;
    logic mul;
    logic prep;
    logic div_step;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

### hw/rtl/rcpd_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
interface rcpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/rcpd_cfg_regs.sv
// Configuration register bank with plain write port.
module rcpd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rcpd_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rcpd_pkg::cfg_t                  cfg
);

  rcpd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width_one <= rcpd_pkg::MIN_WIDTH_RESET;
      cfg_r.max_width_one <= rcpd_pkg::MAX_WIDTH_RESET;
      cfg_r.min_width_two <= rcpd_pkg::MIN_WIDTH_RESET;
      cfg_r.max_width_two <= rcpd_pkg::MAX_WIDTH_RESET;
      cfg_r.fail_limit    <= rcpd_pkg::FAIL_LIMIT_RESET;
      cfg_r.dead_band     <= rcpd_pkg::DEAD_BAND_RESET;
    end else if (cfg_we) begin
      case (rcpd_pkg::cfg_reg_t'(cfg_index))
        rcpd_pkg::REG_MIN_WIDTH_ONE: cfg_r.min_width_one <= cfg_wdata[rcpd_pkg::CAL_W-1:0];
        rcpd_pkg::REG_MAX_WIDTH_ONE: cfg_r.max_width_one <= cfg_wdata[rcpd_pkg::CAL_W-1:0];
        rcpd_pkg::REG_MIN_WIDTH_TWO: cfg_r.min_width_two <= cfg_wdata[rcpd_pkg::CAL_W-1:0];
        rcpd_pkg::REG_MAX_WIDTH_TWO: cfg_r.max_width_two <= cfg_wdata[rcpd_pkg::CAL_W-1:0];
        rcpd_pkg::REG_FAIL_LIMIT:    cfg_r.fail_limit    <= cfg_wdata[rcpd_pkg::FAIL_W-1:0];
        rcpd_pkg::REG_DEAD_BAND:     cfg_r.dead_band     <= cfg_wdata[rcpd_pkg::DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/rcpd_ctrl.sv
// Controller state machine sequencing tracking, mapping and result hand-off.
module rcpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rcpd_pkg::status_t   status,
  output rcpd_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_PREP = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ch_r, ch_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.ch    = ch_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.track = 1'b1;
          ch_nxt    = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/rcpd_datapath.sv
// Datapath with pulse trackers, width mapping multiplier, shared divider and result register.
module rcpd_datapath #(
  parameter int FULL_SCALE = 255,
  parameter int WIDTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rcpd_pkg::cfg_t      cfg,
  input  rcpd_pkg::in_item_t  in_item,
  input  rcpd_pkg::cmd_t      cmd,
  output rcpd_pkg::status_t   status,
  output rcpd_pkg::out_item_t out_item
);

  localparam int WB  = WIDTH_BITS;
  localparam int CW_ = rcpd_pkg::CAL_W;
  localparam int EW  = ((WB > CW_) ? WB : CW_) + 1;
  localparam int QB  = $clog2(2 * FULL_SCALE + 1);
  localparam int PW  = WB + QB;
  localparam int VW  = $clog2(FULL_SCALE + 1);
  localparam int NW  = $clog2(QB);
  localparam int SW  = rcpd_pkg::FAIL_W;
  localparam int DW  = rcpd_pkg::DUTY_W;

  localparam logic [QB-1:0] TWO_FS = QB'(2 * FULL_SCALE);
  localparam logic [QB-1:0] FS_Q   = QB'(FULL_SCALE);
  localparam logic [VW-1:0] FS_V   = VW'(FULL_SCALE);

  logic          last_r  [2];
  logic          await_r [2];
  logic [WB-1:0] hc_r    [2];
  logic [WB-1:0] pw_r    [2];
  logic [SW-1:0] sil_r   [2];
  logic          held_r  [2];
  logic          lv      [2];

  logic [PW-1:0]  num_r;
  logic           bad_r;
  logic           dle0_r;
  logic [CW_-1:0] span_r;
  logic           ovf_r;
  logic [CW_-1:0] rem_r;
  logic [QB-1:0]  low_r;
  logic [QB-1:0]  q_r;
  logic [NW-1:0]  cnt_r;
  logic           neg_r [2];
  logic [VW-1:0]  mag_r [2];
  rcpd_pkg::out_item_t out_r;

  logic [WB-1:0]    w_sel;
  logic [CW_-1:0]   lo_sel;
  logic [CW_-1:0]   hi_sel;
  logic [EW-1:0]    diff;
  logic [PW-1:0]    prod;
  logic [EW-2:0]    hi_part;
  logic             ovf;
  logic [CW_+1:0]   trial;
  logic [QB-1:0]    t_pos;
  logic [VW-1:0]    pos_mag;
  logic [VW-1:0]    neg_mag;
  logic             fin_neg;
  logic [VW-1:0]    fin_mag;
  logic             fail;
  logic [VW+DW-1:0] mag_ext [2];

  assign lv[0] = in_item.pulse_in_one;
  assign lv[1] = in_item.pulse_in_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        last_r[i]  <= 1'b0;
        await_r[i] <= 1'b0;
        hc_r[i]    <= '0;
        pw_r[i]    <= '0;
        sil_r[i]   <= '0;
      end
    end else if (cmd.track) begin
      for (int i = 0; i < 2; i++) begin
        last_r[i] <= lv[i];
        if (await_r[i] && !lv[i]) begin
          pw_r[i]    <= hc_r[i];
          await_r[i] <= 1'b0;
          sil_r[i]   <= '0;
        end else begin
          if (sil_r[i] != '1) begin
            sil_r[i] <= sil_r[i] + 1'b1;
          end
          if (await_r[i]) begin
            if (hc_r[i] != '1) begin
              hc_r[i] <= hc_r[i] + 1'b1;
            end
          end else if (lv[i] && !last_r[i]) begin
            await_r[i] <= 1'b1;
            hc_r[i]    <= WB'(1);
          end
        end
      end
    end
  end

  assign w_sel  = pw_r[cmd.ch];
  assign lo_sel = cmd.ch ? cfg.min_width_two : cfg.min_width_one;
  assign hi_sel = cmd.ch ? cfg.max_width_two : cfg.max_width_one;
  assign diff   = EW'(w_sel) - EW'(lo_sel);
  assign prod   = PW'(diff[WB-1:0]) * PW'(TWO_FS);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r  <= prod;
      bad_r  <= (hi_sel <= lo_sel);
      dle0_r <= diff[EW-1] || (diff == '0);
      span_r <= hi_sel - lo_sel;
    end
  end

  assign hi_part = (EW-1)'(num_r[PW-1:QB]);
  assign ovf     = (hi_part >= (EW-1)'(span_r));
  assign trial   = {1'b0, rem_r, low_r[QB-1]} - {2'b00, span_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ovf_r <= ovf;
      rem_r <= hi_part[CW_-1:0];
      low_r <= num_r[QB-1:0];
      q_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[CW_+1]) begin
        rem_r <= trial[CW_-1:0];
        q_r   <= {q_r[QB-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[CW_-2:0], low_r[QB-1]};
        q_r   <= {q_r[QB-2:0], 1'b0};
      end
      low_r <= {low_r[QB-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.div_done = (cnt_r == NW'(QB - 1));

  assign t_pos   = q_r - FS_Q;
  assign pos_mag = (t_pos > FS_Q) ? FS_V : VW'(t_pos);
  assign neg_mag = VW'(FS_Q - q_r);

  always_comb begin
    if (bad_r) begin
      fin_neg = 1'b0;
      fin_mag = '0;
    end else if (dle0_r) begin
      fin_neg = 1'b1;
      fin_mag = FS_V;
    end else if (ovf_r) begin
      fin_neg = 1'b0;
      fin_mag = FS_V;
    end else if (q_r >= FS_Q) begin
      fin_neg = 1'b0;
      fin_mag = pos_mag;
    end else begin
      fin_neg = 1'b1;
      fin_mag = neg_mag;
    end
    if ((VW+DW)'(fin_mag) < (VW+DW)'(cfg.dead_band)) begin
      fin_neg = 1'b0;
      fin_mag = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      neg_r[cmd.ch] <= fin_neg;
      mag_r[cmd.ch] <= fin_mag;
    end
  end

  assign fail       = (sil_r[0] > cfg.fail_limit) || (sil_r[1] > cfg.fail_limit);
  assign mag_ext[0] = (VW+DW)'(mag_r[0]);
  assign mag_ext[1] = (VW+DW)'(mag_r[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r[0] <= 1'b1;
      held_r[1] <= 1'b1;
    end else if (cmd.out_load && !fail) begin
      held_r[0] <= !neg_r[0];
      held_r[1] <= !neg_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.fail_safe <= fail;
      if (fail) begin
        out_r.forward_one <= held_r[0];
        out_r.forward_two <= held_r[1];
        out_r.duty_one    <= '0;
        out_r.duty_two    <= '0;
      end else begin
        out_r.forward_one <= !neg_r[0];
        out_r.forward_two <= !neg_r[1];
        out_r.duty_one    <= mag_ext[0][DW-1:0];
        out_r.duty_two    <= mag_ext[1][DW-1:0];
      end
    end
  end

  assign out_item = out_r;

endmodule

### hw/rtl/rc_pulse_to_bidirectional_drive_core.sv
// Top level of the RC pulse to bidirectional drive core.
//
//   Channel  Direction  Handshake            Payload
//   in_ch    sink       valid/ready          pulse_in_one, pulse_in_two
//   out_ch   source     valid/ready          forward_one, duty_one, forward_two, duty_two,
//                                            fail_safe
//   cfg      write      cfg_we               cfg_index, cfg_wdata
//
// Each transaction uses the shared restoring divider, Q = clog2(2*FULL_SCALE+1) quotient bits,
// one quotient bit per cycle, run once
// per channel. Reset is synchronous and needs no clearing pass. A finished result waits in
// the output register while the next transaction is accepted; the block stalls only when
// a new result is ready and the previous one has not yet been taken.
module rc_pulse_to_bidirectional_drive_core #(
  parameter int FULL_SCALE = 255,
  parameter int WIDTH_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rcpd_stream_if.sink                     in_ch,
  rcpd_stream_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [rcpd_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rcpd_pkg::cfg_t      cfg;
  rcpd_pkg::cmd_t      cmd;
  rcpd_pkg::status_t   status;
  rcpd_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  rcpd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rcpd_datapath #(
    .FULL_SCALE (FULL_SCALE),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_item  (in_ch.payload),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  a_fail_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.payload.fail_safe |->
      (out_ch.payload.duty_one == '0) && (out_ch.payload.duty_two == '0))
    else $error("Fail-safe result carries a nonzero duty.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("Input ready right after a transaction was accepted.");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("Output register loaded over a result not yet taken.");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.track |-> !(cmd.mul || cmd.prep || cmd.div_step || cmd.fin || cmd.out_load))
    else $error("Tracking overlaps another datapath step.");

endmodule

### tb/tb_rc_pulse_to_bidirectional_drive_core.sv
// Testbench for the RC pulse to bidirectional drive core with its own drive model and checks.
module tb_rc_pulse_to_bidirectional_drive_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SCALE    = 255;
  localparam int WIDTH_BITS    = 16;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_TICKS   = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 60;
  localparam int CYCLE_LIMIT   = 400000;

  localparam int CAL_W      = rcpd_pkg::CAL_W;
  localparam int FAIL_W     = rcpd_pkg::FAIL_W;
  localparam int DB_W       = rcpd_pkg::DB_W;
  localparam int DUTY_W     = rcpd_pkg::DUTY_W;
  localparam int CFG_ADDR_W = rcpd_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = rcpd_pkg::CFG_DATA_W;

  class drive_tracker;
    localparam longint FULL = 255;

    rcpd_pkg::cfg_t      regs;
    logic                last_lv  [2];
    logic                awaiting [2];
    logic                held_dir [2];
    logic [15:0]         high_cnt [2];
    logic [15:0]         width    [2];
    logic [FAIL_W-1:0]   silence  [2];
    rcpd_pkg::out_item_t pending_drives [$];
    int                  errors;
    int                  ticks;
    int                  results;
    int                  fail_results;
    int                  reverse_results;

    function new();
      regs.min_width_one = rcpd_pkg::MIN_WIDTH_RESET;
      regs.max_width_one = rcpd_pkg::MAX_WIDTH_RESET;
      regs.min_width_two = rcpd_pkg::MIN_WIDTH_RESET;
      regs.max_width_two = rcpd_pkg::MAX_WIDTH_RESET;
      regs.fail_limit    = rcpd_pkg::FAIL_LIMIT_RESET;
      regs.dead_band     = rcpd_pkg::DEAD_BAND_RESET;
      for (int ch = 0; ch < 2; ch++) begin
        last_lv[ch]  = 1'b0;
        awaiting[ch] = 1'b0;
        held_dir[ch] = 1'b1;
        high_cnt[ch] = '0;
        width[ch]    = '0;
        silence[ch]  = '0;
      end
      errors = 0;
      ticks = 0;
      results = 0;
      fail_results = 0;
      reverse_results = 0;
    endfunction

    function void write_reg(rcpd_pkg::cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        rcpd_pkg::REG_MIN_WIDTH_ONE: regs.min_width_one = v[CAL_W-1:0];
        rcpd_pkg::REG_MAX_WIDTH_ONE: regs.max_width_one = v[CAL_W-1:0];
        rcpd_pkg::REG_MIN_WIDTH_TWO: regs.min_width_two = v[CAL_W-1:0];
        rcpd_pkg::REG_MAX_WIDTH_TWO: regs.max_width_two = v[CAL_W-1:0];
        rcpd_pkg::REG_FAIL_LIMIT:    regs.fail_limit    = v[FAIL_W-1:0];
        rcpd_pkg::REG_DEAD_BAND:     regs.dead_band     = v[DB_W-1:0];
        default: ;
      endcase
    endfunction

    function bit track(int ch, logic lv);
      bit done;
      done = 1'b0;
      if (awaiting[ch]) begin
        if (lv) begin
          if (high_cnt[ch] != '1) high_cnt[ch]++;
        end else begin
          width[ch] = high_cnt[ch];
          awaiting[ch] = 1'b0;
          done = 1'b1;
        end
      end else if (lv && !last_lv[ch]) begin
        awaiting[ch] = 1'b1;
        high_cnt[ch] = 16'd1;
      end
      last_lv[ch] = lv;
      if (done) begin
        silence[ch] = '0;
      end else if (silence[ch] != '1) begin
        silence[ch]++;
      end
      return done;
    endfunction

    function int map_width(logic [CAL_W-1:0] w, logic [CAL_W-1:0] lo, logic [CAL_W-1:0] hi);
      longint span;
      longint d;
      longint v;
      longint db;
      if (hi <= lo) return 0;
      span = longint'(hi) - longint'(lo);
      d = longint'(w) - longint'(lo);
      db = longint'(regs.dead_band);
      v = (d * (2 * FULL)) / span - FULL;
      if (v < -FULL) v = -FULL;
      if (v > FULL) v = FULL;
      if (v > -db && v < db) v = 0;
      return int'(v);
    endfunction

    function void take_tick(rcpd_pkg::in_item_t t);
      int                  s   [2];
      int                  mag [2];
      logic                fail;
      rcpd_pkg::out_item_t d;
      void'(track(0, t.pulse_in_one));
      void'(track(1, t.pulse_in_two));
      fail = (silence[0] > regs.fail_limit) || (silence[1] > regs.fail_limit);
      s[0] = map_width(width[0], regs.min_width_one, regs.max_width_one);
      s[1] = map_width(width[1], regs.min_width_two, regs.max_width_two);
      for (int ch = 0; ch < 2; ch++) begin
        if (fail) begin
          mag[ch] = 0;
        end else if (s[ch] >= 0) begin
          held_dir[ch] = 1'b1;
          mag[ch] = s[ch];
        end else begin
          held_dir[ch] = 1'b0;
          mag[ch] = -s[ch];
        end
      end
      d.forward_one = held_dir[0];
      d.duty_one    = DUTY_W'(mag[0]);
      d.forward_two = held_dir[1];
      d.duty_two    = DUTY_W'(mag[1]);
      d.fail_safe   = fail;
      pending_drives.push_back(d);
      ticks++;
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction

    task flag(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_drive(rcpd_pkg::out_item_t got);
      rcpd_pkg::out_item_t want;
      if (pending_drives.size() == 0) begin
        flag("drive result arrived with no tick waiting");
        return;
      end
      want = pending_drives.pop_front();
      if (got.forward_one !== want.forward_one)
        flag($sformatf("result %0d forward_one got %0b want %0b",
                       results, got.forward_one, want.forward_one));
      if (got.duty_one !== want.duty_one)
        flag($sformatf("result %0d duty_one got %0d want %0d",
                       results, got.duty_one, want.duty_one));
      if (got.forward_two !== want.forward_two)
        flag($sformatf("result %0d forward_two got %0b want %0b",
                       results, got.forward_two, want.forward_two));
      if (got.duty_two !== want.duty_two)
        flag($sformatf("result %0d duty_two got %0d want %0d",
                       results, got.duty_two, want.duty_two));
      if (got.fail_safe !== want.fail_safe)
        flag($sformatf("result %0d fail_safe got %0b want %0b",
                       results, got.fail_safe, want.fail_safe));
      if (want.fail_safe) fail_results++;
      if (!want.forward_one || !want.forward_two) reverse_results++;
      results++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;
  int          settings = 0;
  int unsigned cycles = 0;
  int          gen_left [2] = '{0, 0};
  logic        gen_lvl  [2] = '{1'b0, 1'b0};

  drive_tracker drive = new();

  rcpd_stream_if #(.payload_t(rcpd_pkg::in_item_t))  in_ch ();
  rcpd_stream_if #(.payload_t(rcpd_pkg::out_item_t)) out_ch ();

  rc_pulse_to_bidirectional_drive_core #(
    .FULL_SCALE(FULL_SCALE),
    .WIDTH_BITS(WIDTH_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: cycle limit reached");
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) drive.write_reg(rcpd_pkg::cfg_reg_t'(cfg_index), cfg_wdata);
      if (in_ch.valid && in_ch.ready) drive.take_tick(in_ch.payload);
      if (out_ch.valid && out_ch.ready) drive.compare_drive(out_ch.payload);
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  task automatic send_tick(logic one, logic two);
    rcpd_pkg::in_item_t t;
    t.pulse_in_one = one;
    t.pulse_in_two = two;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic send_pulses(int w1, int w2);
    int span;
    span = (w1 > w2) ? w1 : w2;
    for (int i = 0; i <= span; i++) send_tick(i < w1, i < w2);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drive.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(rcpd_pkg::cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic apply_setting(rcpd_pkg::cfg_t c);
    put_reg(rcpd_pkg::REG_MIN_WIDTH_ONE, CFG_DATA_W'(c.min_width_one));
    put_reg(rcpd_pkg::REG_MAX_WIDTH_ONE, CFG_DATA_W'(c.max_width_one));
    put_reg(rcpd_pkg::REG_MIN_WIDTH_TWO, CFG_DATA_W'(c.min_width_two));
    put_reg(rcpd_pkg::REG_MAX_WIDTH_TWO, CFG_DATA_W'(c.max_width_two));
    put_reg(rcpd_pkg::REG_FAIL_LIMIT, CFG_DATA_W'(c.fail_limit));
    put_reg(rcpd_pkg::REG_DEAD_BAND, CFG_DATA_W'(c.dead_band));
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic void pick_cal(output logic [CAL_W-1:0] lo, output logic [CAL_W-1:0] hi);
    int base;
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = CAL_W'($urandom);
        hi = CAL_W'($urandom);
      end
      2: begin
        base = $urandom_range(0, 20);
        lo = CAL_W'(base);
        hi = CAL_W'(base - $urandom_range(0, base));
      end
      default: begin
        base = $urandom_range(0, 12);
        lo = CAL_W'(base);
        hi = CAL_W'(base + $urandom_range(1, 24));
      end
    endcase
  endfunction

  function automatic rcpd_pkg::cfg_t random_setting();
    rcpd_pkg::cfg_t c;
    pick_cal(c.min_width_one, c.max_width_one);
    pick_cal(c.min_width_two, c.max_width_two);
    case ($urandom_range(0, 5))
      0:       c.fail_limit = '0;
      1:       c.fail_limit = '1;
      2:       c.fail_limit = FAIL_W'($urandom);
      default: c.fail_limit = FAIL_W'($urandom_range(1, 60));
    endcase
    case ($urandom_range(0, 4))
      0:       c.dead_band = '0;
      1:       c.dead_band = '1;
      2:       c.dead_band = DB_W'($urandom);
      default: c.dead_band = DB_W'($urandom_range(0, 60));
    endcase
    return c;
  endfunction

  function automatic logic next_level(int ch, int hi_max);
    if (gen_left[ch] == 0) begin
      gen_lvl[ch] = !gen_lvl[ch];
      if (gen_lvl[ch]) begin
        gen_left[ch] = $urandom_range(1, hi_max);
      end else if ($urandom_range(0, 9) == 0) begin
        gen_left[ch] = $urandom_range(20, 90);
      end else begin
        gen_left[ch] = $urandom_range(1, 8);
      end
    end
    gen_left[ch]--;
    if ($urandom_range(0, 99) < 5) return logic'($urandom_range(0, 1));
    return gen_lvl[ch];
  endfunction

  initial begin
    rcpd_pkg::cfg_t setting;
    int             hi_max;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset calibration, short pulses and the empty width map to full reverse.
    send_pulses(3, 3);
    wait_drained();

    setting.min_width_one = 16'd2;
    setting.max_width_one = 16'd6;
    setting.min_width_two = '1;
    setting.max_width_two = '0;
    setting.fail_limit    = '1;
    setting.dead_band     = '0;
    apply_setting(setting);
    send_pulses(1, 1);
    send_pulses(8, 3);
    send_pulses(4, 5);
    wait_drained();

    // A zero silence limit trips on every tick that does not close a pulse on both lines.
    setting.min_width_two = '0;
    setting.max_width_two = '1;
    setting.fail_limit    = '0;
    setting.dead_band     = '1;
    apply_setting(setting);
    send_pulses(3, 3);
    send_pulses(6, 6);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setting = random_setting();
      quiet = (p == 4 || p == 5);
      apply_setting(setting);
      hi_max = (setting.max_width_one > setting.max_width_two) ?
               int'(setting.max_width_one) : int'(setting.max_width_two);
      hi_max = hi_max + 6;
      if (hi_max > 40) hi_max = 40;
      if (hi_max < 8) hi_max = 8;
      if (p == 8) hold_req = 1'b1;
      for (int n = 0; n < PHASE_TICKS; n++)
        send_tick(next_level(0, hi_max), next_level(1, hi_max));
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (drive.pending() != 0)
      drive.flag($sformatf("%0d drive results never arrived", drive.pending()));
    $display("run covered %0d ticks under %0d register settings", drive.ticks, settings);
    $display("%0d results checked, %0d in fail-safe, %0d with a reverse direction",
             drive.results, drive.fail_results, drive.reverse_results);
    if (drive.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### rc_pulse_to_bidirectional_drive_core.f
hw/rtl/rcpd_pkg.sv
hw/rtl/rcpd_stream_if.sv
hw/rtl/rcpd_cfg_regs.sv
hw/rtl/rcpd_ctrl.sv
hw/rtl/rcpd_datapath.sv
hw/rtl/rc_pulse_to_bidirectional_drive_core.sv
tb/tb_rc_pulse_to_bidirectional_drive_core.sv
